// ===== rtl/s5rp_pkg.sv =====
// Shared types, phase codes and protocol constants for the SOCKS5 request parser.
`timescale 1ns / 1ps

package s5rp_pkg;

	// Phase codes as reported on the result beat
	localparam logic [3:0] PH_VERSION  = 4'd0;
	localparam logic [3:0] PH_CMD      = 4'd1;
	localparam logic [3:0] PH_RSV      = 4'd2;
	localparam logic [3:0] PH_ATYP     = 4'd3;
	localparam logic [3:0] PH_NAMELEN  = 4'd4;
	localparam logic [3:0] PH_ADDR     = 4'd5;
	localparam logic [3:0] PH_PORT     = 4'd6;
	localparam logic [3:0] PH_DONE     = 4'd7;
	localparam logic [3:0] PH_BAD_VER  = 4'd8;
	localparam logic [3:0] PH_BAD_CMD  = 4'd9;
	localparam logic [3:0] PH_BAD_ATYP = 4'd10;

	// Protocol constants
	localparam logic [7:0] SOCKS_VERSION = 8'h05;
	localparam logic [7:0] CMD_MIN       = 8'd1;
	localparam logic [7:0] CMD_MAX       = 8'd3;
	localparam logic [7:0] ATYP_IPV4     = 8'd1;
	localparam logic [7:0] ATYP_DOMAIN   = 8'd3;
	localparam logic [7:0] ATYP_IPV6     = 8'd4;
	localparam logic [7:0] IPV4_LEN      = 8'd4;
	localparam logic [7:0] IPV6_LEN      = 8'd16;
	localparam logic [7:0] PORT_LEN      = 8'd2;

	// Item function codes
	localparam logic FUNC_BYTE  = 1'b0;
	localparam logic FUNC_CLEAR = 1'b1;

	// Parser state, one-hot
	typedef enum logic [10:0] {
		ST_VERSION  = 11'b000_0000_0001,
		ST_CMD      = 11'b000_0000_0010,
		ST_RSV      = 11'b000_0000_0100,
		ST_ATYP     = 11'b000_0000_1000,
		ST_NAMELEN  = 11'b000_0001_0000,
		ST_ADDR     = 11'b000_0010_0000,
		ST_PORT     = 11'b000_0100_0000,
		ST_DONE     = 11'b000_1000_0000,
		ST_BAD_VER  = 11'b001_0000_0000,
		ST_BAD_CMD  = 11'b010_0000_0000,
		ST_BAD_ATYP = 11'b100_0000_0000
	} state_t;

	// One result beat
	typedef struct packed {
		logic [3:0]  phase;
		logic        finished;
		logic        failed;
		logic [1:0]  command;
		logic [2:0]  addr_kind;
		logic [7:0]  addr_byte;
		logic [7:0]  addr_index;
		logic        addr_valid;
		logic        addr_last;
		logic [15:0] port_value;
		logic        port_valid;
	} res_t;

	// Phase code for a parser state
	function automatic logic [3:0] phase_code(input state_t st);
		logic [3:0] code;
		case (st)
			ST_VERSION:  code = PH_VERSION;
			ST_CMD:      code = PH_CMD;
			ST_RSV:      code = PH_RSV;
			ST_ATYP:     code = PH_ATYP;
			ST_NAMELEN:  code = PH_NAMELEN;
			ST_ADDR:     code = PH_ADDR;
			ST_PORT:     code = PH_PORT;
			ST_DONE:     code = PH_DONE;
			ST_BAD_VER:  code = PH_BAD_VER;
			ST_BAD_CMD:  code = PH_BAD_CMD;
			ST_BAD_ATYP: code = PH_BAD_ATYP;
			default:     code = PH_VERSION;
		endcase
		return code;
	endfunction

endpackage

// ===== rtl/socks5_request_parser_unit.sv =====
// Top level of the SOCKS5 request parser: input register, parser core, result register.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  request | req_valid, req_stall, func, byte_in       | in
//  result  | res_valid, res_stall, phase .. port_valid | out
//
// One byte per cycle while res_stall is low: a beat is registered in the input
// register, parsed by the core and its result registered in the result register;
// the rate is set by the single parser state update per byte.
// arst_n clears the parser to expect the version byte and empties both registers.
// res_stall holds the result register; the input register then holds too and
// req_stall rises while it is full and cannot move on.
`timescale 1ns / 1ps

module socks5_request_parser_unit import s5rp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic        func,
	input  logic [7:0]  byte_in,
	output logic        res_valid,
	input  logic        res_stall,
	output logic [3:0]  phase,
	output logic        finished,
	output logic        failed,
	output logic [1:0]  command,
	output logic [2:0]  addr_kind,
	output logic [7:0]  addr_byte,
	output logic [7:0]  addr_index,
	output logic        addr_valid,
	output logic        addr_last,
	output logic [15:0] port_value,
	output logic        port_valid
);

	logic       valid_s1;
	logic       func_s1;
	logic [7:0] byte_s1;
	logic       advance;
	logic       take;
	res_t       res_c;
	res_t       res_s2;

	// Handshake: stage 1 moves on when the result register is free
	assign advance   = valid_s1 && (!res_valid || !res_stall);
	assign req_stall = valid_s1 && !advance;
	assign take      = req_valid && !req_stall;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			func_s1 <= func;
			byte_s1 <= byte_in;
		end
	end

	s5rp_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.func    (func_s1),
		.byte_in (byte_s1),
		.res     (res_c)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (advance) begin
			res_valid <= 1'b1;
		end else if (!res_stall) begin
			res_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_c;
		end
	end

	assign phase      = res_s2.phase;
	assign finished   = res_s2.finished;
	assign failed     = res_s2.failed;
	assign command    = res_s2.command;
	assign addr_kind  = res_s2.addr_kind;
	assign addr_byte  = res_s2.addr_byte;
	assign addr_index = res_s2.addr_index;
	assign addr_valid = res_s2.addr_valid;
	assign addr_last  = res_s2.addr_last;
	assign port_value = res_s2.port_value;
	assign port_valid = res_s2.port_valid;

endmodule

// ===== rtl/s5rp_core.sv =====
// Parser state registers and the per-byte next-state and result logic.
`timescale 1ns / 1ps

module s5rp_core import s5rp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic       func,
	input  logic [7:0] byte_in,
	output res_t       res
);

	state_t      state_q, state_d;
	logic [7:0]  rd_q, rd_d;
	logic [7:0]  exp_q, exp_d;
	logic [1:0]  cmd_q, cmd_d;
	logic [2:0]  kind_q, kind_d;
	logic [7:0]  porthi_q, porthi_d;
	logic [7:0]  rd_inc;
	logic [3:0]  code_d;

	assign rd_inc = rd_q + 8'd1;
	assign code_d = phase_code(state_d);

	// Next state and per-beat result fields
	always_comb begin
		state_d  = state_q;
		rd_d     = rd_q;
		exp_d    = exp_q;
		cmd_d    = cmd_q;
		kind_d   = kind_q;
		porthi_d = porthi_q;
		res      = '0;
		if (func == FUNC_CLEAR) begin
			state_d  = ST_VERSION;
			rd_d     = '0;
			exp_d    = '0;
			cmd_d    = '0;
			kind_d   = '0;
			porthi_d = '0;
		end else begin
			case (state_q)
				ST_VERSION: begin
					state_d = (byte_in == SOCKS_VERSION) ? ST_CMD : ST_BAD_VER;
				end
				ST_CMD: begin
					if (byte_in >= CMD_MIN && byte_in <= CMD_MAX) begin
						cmd_d   = byte_in[1:0];
						state_d = ST_RSV;
					end else begin
						state_d = ST_BAD_CMD;
					end
				end
				ST_RSV: begin
					state_d = ST_ATYP;
				end
				ST_ATYP: begin
					if (byte_in == ATYP_IPV4) begin
						kind_d  = byte_in[2:0];
						exp_d   = IPV4_LEN;
						rd_d    = '0;
						state_d = ST_ADDR;
					end else if (byte_in == ATYP_DOMAIN) begin
						kind_d  = byte_in[2:0];
						state_d = ST_NAMELEN;
					end else if (byte_in == ATYP_IPV6) begin
						kind_d  = byte_in[2:0];
						exp_d   = IPV6_LEN;
						rd_d    = '0;
						state_d = ST_ADDR;
					end else begin
						state_d = ST_BAD_ATYP;
					end
				end
				ST_NAMELEN: begin
					// empty domain name counts as a bad address type
					if (byte_in == 8'd0) begin
						state_d = ST_BAD_ATYP;
					end else begin
						exp_d   = byte_in;
						rd_d    = '0;
						state_d = ST_ADDR;
					end
				end
				ST_ADDR: begin
					res.addr_byte  = byte_in;
					res.addr_index = rd_q;
					res.addr_valid = 1'b1;
					rd_d           = rd_inc;
					if (rd_inc >= exp_q) begin
						res.addr_last = 1'b1;
						exp_d         = PORT_LEN;
						rd_d          = '0;
						porthi_d      = '0;
						state_d       = ST_PORT;
					end
				end
				ST_PORT: begin
					if (rd_q == 8'd0) begin
						porthi_d = byte_in;
						rd_d     = 8'd1;
					end else begin
						res.port_value = {porthi_q, byte_in};
						res.port_valid = 1'b1;
						rd_d           = PORT_LEN;
						state_d        = ST_DONE;
					end
				end
				default: begin
					// done and error states hold
				end
			endcase
		end
		res.phase     = code_d;
		res.finished  = (code_d >= PH_DONE);
		res.failed    = (code_d >= PH_BAD_VER);
		res.command   = cmd_d;
		res.addr_kind = kind_d;
	end

	// State update once per accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_VERSION;
			rd_q     <= '0;
			exp_q    <= '0;
			cmd_q    <= '0;
			kind_q   <= '0;
			porthi_q <= '0;
		end else if (step) begin
			state_q  <= state_d;
			rd_q     <= rd_d;
			exp_q    <= exp_d;
			cmd_q    <= cmd_d;
			kind_q   <= kind_d;
			porthi_q <= porthi_d;
		end
	end

endmodule

// ===== tb/sv/socks5_request_parser_unit_tb.sv =====
// Self-checking testbench for the SOCKS5 request parser unit: directed table, then random requests.
`timescale 1ns / 1ps

module socks5_request_parser_unit_tb;
	import s5rp_pkg::*;

	localparam int RAND_ITEMS   = 1700;
	localparam int DRAIN_CYCLES = 8;
	localparam int IDLE_PCT     = 18;

	// One row of the directed table; want is used only where typed is set
	typedef struct packed {
		logic       fn;
		logic [7:0] data;
		logic       typed;
		res_t       want;
	} stim_row_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_stall;
	logic        func      = FUNC_BYTE;
	logic [7:0]  byte_in   = 8'h00;
	logic        res_valid;
	logic        res_stall = 1'b0;
	logic [3:0]  phase;
	logic        finished;
	logic        failed;
	logic [1:0]  command;
	logic [2:0]  addr_kind;
	logic [7:0]  addr_byte;
	logic [7:0]  addr_index;
	logic        addr_valid;
	logic        addr_last;
	logic [15:0] port_value;
	logic        port_valid;

	// Parser model state
	logic [3:0] pm_phase;
	logic [7:0] pm_read;
	logic [7:0] pm_expect;
	logic [7:0] pm_port_hi;
	logic [1:0] pm_cmd;
	logic [2:0] pm_kind;

	res_t        parse_results[$];
	stim_row_t   dir_rows[$];
	logic [8:0]  request_beats[$];
	int          fail_count = 0;
	int          parsed_count = 0;
	bit          calm = 1'b0;

	socks5_request_parser_unit u_top (.*);

	// Clock
	initial begin
		forever #5 clk = ~clk;
	end

	// Run limit
	initial begin
		#5ms;
		$display("FAIL socks5_request_parser_unit");
		$finish;
	end

	function automatic void clear_parser();
		pm_phase   = PH_VERSION;
		pm_read    = 8'd0;
		pm_expect  = 8'd0;
		pm_port_hi = 8'd0;
		pm_cmd     = 2'd0;
		pm_kind    = 3'd0;
	endfunction

	// Advance the parser model by one beat and return the result it reports
	function automatic res_t parse_step(input logic fn, input logic [7:0] b);
		res_t r;
		r = '0;
		if (fn == FUNC_CLEAR) begin
			clear_parser();
		end else begin
			case (pm_phase)
				PH_VERSION: pm_phase = (b == SOCKS_VERSION) ? PH_CMD : PH_BAD_VER;
				PH_CMD: begin
					if (b >= CMD_MIN && b <= CMD_MAX) begin
						pm_cmd   = b[1:0];
						pm_phase = PH_RSV;
					end else begin
						pm_phase = PH_BAD_CMD;
					end
				end
				PH_RSV: pm_phase = PH_ATYP;
				PH_ATYP: begin
					if (b == ATYP_IPV4 || b == ATYP_IPV6) begin
						pm_kind   = b[2:0];
						pm_expect = (b == ATYP_IPV4) ? IPV4_LEN : IPV6_LEN;
						pm_read   = 8'd0;
						pm_phase  = PH_ADDR;
					end else if (b == ATYP_DOMAIN) begin
						pm_kind  = b[2:0];
						pm_phase = PH_NAMELEN;
					end else begin
						pm_phase = PH_BAD_ATYP;
					end
				end
				PH_NAMELEN: begin
					// an empty name counts as a bad address type
					if (b == 8'd0) begin
						pm_phase = PH_BAD_ATYP;
					end else begin
						pm_expect = b;
						pm_read   = 8'd0;
						pm_phase  = PH_ADDR;
					end
				end
				PH_ADDR: begin
					r.addr_byte  = b;
					r.addr_index = pm_read;
					r.addr_valid = 1'b1;
					pm_read      = pm_read + 8'd1;
					if (pm_read >= pm_expect) begin
						r.addr_last = 1'b1;
						pm_expect   = PORT_LEN;
						pm_read     = 8'd0;
						pm_port_hi  = 8'd0;
						pm_phase    = PH_PORT;
					end
				end
				PH_PORT: begin
					if (pm_read == 8'd0) begin
						pm_port_hi = b;
						pm_read    = 8'd1;
					end else begin
						r.port_value = {pm_port_hi, b};
						r.port_valid = 1'b1;
						pm_read      = PORT_LEN;
						pm_phase     = PH_DONE;
					end
				end
				default: ;
			endcase
		end
		r.phase     = pm_phase;
		r.finished  = (pm_phase >= PH_DONE);
		r.failed    = (pm_phase >= PH_BAD_VER);
		r.command   = pm_cmd;
		r.addr_kind = pm_kind;
		return r;
	endfunction

	// Status-only result, as typed into the table
	function automatic res_t status_res(input logic [3:0] ph, input logic fin, input logic bad,
			input logic [1:0] cmd, input logic [2:0] kind);
		res_t r;
		r = '0;
		r.phase     = ph;
		r.finished  = fin;
		r.failed    = bad;
		r.command   = cmd;
		r.addr_kind = kind;
		return r;
	endfunction

	function automatic stim_row_t mk_row(input logic fn, input logic [7:0] b, input logic typed,
			input res_t want);
		stim_row_t row;
		row.fn    = fn;
		row.data  = b;
		row.typed = typed;
		row.want  = want;
		return row;
	endfunction

	// Send one request beat; called just after a rising edge
	task automatic send_beat(input logic fn, input logic [7:0] b, input logic typed,
			input res_t want);
		res_t pred;
		bit   taken;
		if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		func      <= fn;
		byte_in   <= b;
		// handshake is decided on the values held over the falling edge
		do begin
			@(negedge clk);
			taken = !req_stall;
			@(posedge clk);
		end while (!taken);
		parsed_count++;
		pred = parse_step(fn, b);
		parse_results.push_back(typed ? want : pred);
	endtask

	task automatic wait_results_drained();
		req_valid <= 1'b0;
		while (parse_results.size() != 0) @(posedge clk);
	endtask

	// Build one random request: mostly well formed, some corrupted, some plain noise
	task automatic build_request();
		int          pick;
		int          kind_pick;
		int          pos;
		int          n;
		logic [7:0]  len;
		request_beats.delete();
		request_beats.push_back({FUNC_CLEAR, 8'($urandom_range(0, 255))});
		pick = $urandom_range(0, 99);
		if (pick < 6) begin
			n = $urandom_range(1, 12);
			repeat (n) begin
				request_beats.push_back({($urandom_range(0, 99) < 10) ? FUNC_CLEAR : FUNC_BYTE,
					8'($urandom_range(0, 255))});
			end
		end else begin
			request_beats.push_back({FUNC_BYTE, SOCKS_VERSION});
			request_beats.push_back({FUNC_BYTE, 8'($urandom_range(1, 3))});
			request_beats.push_back({FUNC_BYTE, 8'($urandom_range(0, 255))});
			kind_pick = $urandom_range(0, 99);
			if (kind_pick < 40) begin
				request_beats.push_back({FUNC_BYTE, ATYP_IPV4});
				len = IPV4_LEN;
			end else if (kind_pick < 75) begin
				request_beats.push_back({FUNC_BYTE, ATYP_DOMAIN});
				len = ($urandom_range(0, 29) == 0) ? 8'd255 : 8'($urandom_range(1, 12));
				request_beats.push_back({FUNC_BYTE, len});
			end else begin
				request_beats.push_back({FUNC_BYTE, ATYP_IPV6});
				len = IPV6_LEN;
			end
			repeat (len) request_beats.push_back({FUNC_BYTE, 8'($urandom_range(0, 255))});
			repeat (2) request_beats.push_back({FUNC_BYTE, 8'($urandom_range(0, 255))});
			// corrupt one beat: a random byte, or a clear in mid request
			if (pick < 20) begin
				pos = $urandom_range(1, request_beats.size() - 1);
				request_beats[pos] = {($urandom_range(0, 3) == 0) ? FUNC_CLEAR : FUNC_BYTE,
					8'($urandom_range(0, 255))};
			end
			repeat ($urandom_range(0, 2))
				request_beats.push_back({FUNC_BYTE, 8'($urandom_range(0, 255))});
		end
	endtask

	task automatic check_field(input string name, input int unsigned want, input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endtask

	// Result side: random stall, driven at the rising edge
	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			res_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
		end
	end

	// Result monitor: a beat valid and unstalled over the falling edge is taken at the next rise
	initial begin
		res_t want;
		forever begin
			@(negedge clk);
			if (arst_n && res_valid && !res_stall) begin
				if (parse_results.size() == 0) begin
					$error("result beat with no expectation waiting");
					fail_count++;
				end else begin
					want = parse_results.pop_front();
					check_field("phase", want.phase, phase);
					check_field("finished", want.finished, finished);
					check_field("failed", want.failed, failed);
					check_field("command", want.command, command);
					check_field("addr_kind", want.addr_kind, addr_kind);
					check_field("addr_byte", want.addr_byte, addr_byte);
					check_field("addr_index", want.addr_index, addr_index);
					check_field("addr_valid", want.addr_valid, addr_valid);
					check_field("addr_last", want.addr_last, addr_last);
					check_field("port_value", want.port_value, port_value);
					check_field("port_valid", want.port_valid, port_valid);
				end
			end
		end
	end

	// Stimulus
	initial begin
		res_t zero_res;
		bit   paused;
		clear_parser();
		zero_res = status_res(PH_VERSION, 1'b0, 1'b0, 2'd0, 3'd0);
		paused   = 1'b0;

		// bad version, bad command
		dir_rows.push_back(mk_row(FUNC_CLEAR, 8'hFF, 1'b1, zero_res));
		dir_rows.push_back(mk_row(FUNC_BYTE, 8'hFF, 1'b1,
			status_res(PH_BAD_VER, 1'b1, 1'b1, 2'd0, 3'd0)));
		dir_rows.push_back(mk_row(FUNC_CLEAR, 8'h00, 1'b1, zero_res));
		dir_rows.push_back(mk_row(FUNC_BYTE, SOCKS_VERSION, 1'b0, zero_res));
		dir_rows.push_back(mk_row(FUNC_BYTE, 8'h00, 1'b1,
			status_res(PH_BAD_CMD, 1'b1, 1'b1, 2'd0, 3'd0)));
		// unknown address type, reserved byte at its maximum
		dir_rows.push_back(mk_row(FUNC_CLEAR, 8'h5A, 1'b1, zero_res));
		dir_rows.push_back(mk_row(FUNC_BYTE, SOCKS_VERSION, 1'b0, zero_res));
		dir_rows.push_back(mk_row(FUNC_BYTE, 8'd3, 1'b0, zero_res));
		dir_rows.push_back(mk_row(FUNC_BYTE, 8'hFF, 1'b0, zero_res));
		dir_rows.push_back(mk_row(FUNC_BYTE, 8'd2, 1'b1,
			status_res(PH_BAD_ATYP, 1'b1, 1'b1, 2'd3, 3'd0)));
		// empty domain name
		dir_rows.push_back(mk_row(FUNC_CLEAR, 8'h00, 1'b1, zero_res));
		dir_rows.push_back(mk_row(FUNC_BYTE, SOCKS_VERSION, 1'b0, zero_res));
		dir_rows.push_back(mk_row(FUNC_BYTE, 8'd1, 1'b0, zero_res));
		dir_rows.push_back(mk_row(FUNC_BYTE, 8'h00, 1'b0, zero_res));
		dir_rows.push_back(mk_row(FUNC_BYTE, ATYP_DOMAIN, 1'b0, zero_res));
		dir_rows.push_back(mk_row(FUNC_BYTE, 8'h00, 1'b1,
			status_res(PH_BAD_ATYP, 1'b1, 1'b1, 2'd1, 3'd3)));
		// full IPv4 request with extreme bytes, then a byte after done
		dir_rows.push_back(mk_row(FUNC_CLEAR, 8'h00, 1'b1, zero_res));
		dir_rows.push_back(mk_row(FUNC_BYTE, SOCKS_VERSION, 1'b0, zero_res));
		dir_rows.push_back(mk_row(FUNC_BYTE, 8'd2, 1'b0, zero_res));
		dir_rows.push_back(mk_row(FUNC_BYTE, 8'h00, 1'b0, zero_res));
		dir_rows.push_back(mk_row(FUNC_BYTE, ATYP_IPV4, 1'b0, zero_res));
		dir_rows.push_back(mk_row(FUNC_BYTE, 8'h00, 1'b0, zero_res));
		dir_rows.push_back(mk_row(FUNC_BYTE, 8'hFF, 1'b0, zero_res));
		dir_rows.push_back(mk_row(FUNC_BYTE, 8'h00, 1'b0, zero_res));
		dir_rows.push_back(mk_row(FUNC_BYTE, 8'hFF, 1'b0, zero_res));
		dir_rows.push_back(mk_row(FUNC_BYTE, 8'hFF, 1'b0, zero_res));
		dir_rows.push_back(mk_row(FUNC_BYTE, 8'hFF, 1'b0, zero_res));
		dir_rows.push_back(mk_row(FUNC_BYTE, 8'h00, 1'b0, zero_res));

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_beat(dir_rows[i].fn, dir_rows[i].data, dir_rows[i].typed, dir_rows[i].want);
		wait_results_drained();

		// random requests, with a stretch of no idling on either side
		parsed_count = 0;
		while (parsed_count < RAND_ITEMS) begin
			build_request();
			foreach (request_beats[i]) begin
				calm = (parsed_count >= 600 && parsed_count < 900);
				send_beat(request_beats[i][8], request_beats[i][7:0], 1'b0, zero_res);
			end
			if (!paused && parsed_count >= RAND_ITEMS / 2) begin
				paused = 1'b1;
				wait_results_drained();
			end
		end

		// drain and finish
		wait_results_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("PASS socks5_request_parser_unit");
		end else begin
			$display("FAIL socks5_request_parser_unit");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/s5rp_pkg.sv
rtl/s5rp_core.sv
rtl/socks5_request_parser_unit.sv
tb/sv/socks5_request_parser_unit_tb.sv
